[rtl/fsp_pkg.sv]
// Shared types and constants for the conversion specification parser.
`timescale 1ns / 1ps

package fsp_pkg;

    // Character codes that steer the parse
    localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
    localparam logic [7:0] CH_MINUS   = 8'h2D;  // '-'
    localparam logic [7:0] CH_STAR    = 8'h2A;  // '*'
    localparam logic [7:0] CH_DOT     = 8'h2E;  // '.'
    localparam logic [7:0] CH_LC_C    = 8'h63;  // 'c'
    localparam logic [7:0] CH_LC_S    = 8'h73;  // 's'
    localparam logic [7:0] CH_LC_P    = 8'h70;  // 'p'
    localparam logic [7:0] CH_LC_D    = 8'h64;  // 'd'
    localparam logic [7:0] CH_LC_I    = 8'h69;  // 'i'
    localparam logic [7:0] CH_LC_U    = 8'h75;  // 'u'
    localparam logic [7:0] CH_LC_X    = 8'h78;  // 'x'
    localparam logic [7:0] CH_UC_X    = 8'h58;  // 'X'
    localparam logic [7:0] CH_PERCENT = 8'h25;  // '%'

    // Conversion codes as they appear on the result
    localparam logic [3:0] CONV_NONE    = 4'd0;
    localparam logic [3:0] CONV_C       = 4'd1;
    localparam logic [3:0] CONV_S       = 4'd2;
    localparam logic [3:0] CONV_P       = 4'd3;
    localparam logic [3:0] CONV_D       = 4'd4;
    localparam logic [3:0] CONV_I       = 4'd5;
    localparam logic [3:0] CONV_U       = 4'd6;
    localparam logic [3:0] CONV_LX      = 4'd7;
    localparam logic [3:0] CONV_UX      = 4'd8;
    localparam logic [3:0] CONV_PERCENT = 4'd9;

    // Saturation limit for widths and decimal precisions
    localparam logic [30:0] SAT_MAX = 31'h7FFF_FFFF;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Stream payload widths
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 72;

    typedef enum logic [2:0] {
        K_DIGIT,
        K_MINUS,
        K_STAR,
        K_DOT,
        K_CONV,
        K_OTHER
    } t_kind;

    // One classified request
    typedef struct packed {
        t_kind              kind;
        logic        [3:0]  digit;
        logic        [3:0]  conv;
        logic signed [31:0] star;
    } t_item;

    // One result as carried on the output stream
    typedef struct packed {
        logic               char_consumed;
        logic signed [31:0] precision;
        logic               precision_given;
        logic        [30:0] field_width;
        logic               left_justify;
        logic               zero_pad;
        logic        [3:0]  conversion;
    } t_result;

endpackage

[rtl/format_spec_parser.sv]
// Top level of the printf-style conversion specification parser.
//
// Usage:
//   s_axis carries one character of a format string per request, together
//   with the argument value that a '*' in that position takes. The first
//   character of each specification (the introducer) is skipped; flags,
//   width and precision follow, and a conversion letter or any unexpected
//   character closes the specification and produces one result on m_axis.
// Result path: when the request queue is empty, the closing character's
//   request is written into the queue as it is accepted, and the result
//   register then loads from the queue head and offers the result on m_axis.
// Throughput: one character per cycle while the receiver takes results and
//   the queue is not full. Each character is one step of the back end (one
//   shared multiply-by-ten add with saturation).
// Reset (i_rst_n low at a clock edge): empties the four-entry request
//   queue, drops any held result and returns the parser to await an
//   introducer.
// Receiver stall: a finished result waits in the output register; the back
//   end keeps consuming characters that produce no result, holds at the next
//   closing character, and s_axis_tready falls once the queue holds four
//   requests, the blocked one included.
`timescale 1ns / 1ps

module format_spec_parser
    import fsp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [7:0] in_char, [39:8] star_value
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [3:0] conversion, [4] zero_pad, [5] left_justify, [36:6] field_width,
    // [37] precision_given, [69:38] precision, [70] char_consumed, [71] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_item   w_front_item;
    t_item   w_queue_item;
    logic    w_queue_full;
    logic    w_queue_valid;
    logic    w_pop;
    t_result w_result;

    // Classify the incoming character
    fsp_front u_front (
        .i_char (s_axis_tdata[7:0]),
        .i_star (s_axis_tdata[39:8]),
        .o_item (w_front_item)
    );

    // Hold classified requests until the parser takes them
    fsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_item  (w_front_item),
        .o_full  (w_queue_full),
        .i_pop   (w_pop),
        .o_valid (w_queue_valid),
        .o_item  (w_queue_item)
    );

    // Advance the parse and register each result
    fsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_queue_valid),
        .i_item      (w_queue_item),
        .o_pop       (w_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_result    (w_result)
    );

    assign s_axis_tready = !w_queue_full;
    // Pad the 71-bit result with a zero bit up to whole bytes
    assign m_axis_tdata  = {1'b0, w_result};

endmodule

[rtl/fsp_front.sv]
// Front end: classifies each incoming character into a parse request.
`timescale 1ns / 1ps

module fsp_front
    import fsp_pkg::*;
(
    input  logic        [7:0]  i_char,
    input  logic signed [31:0] i_star,
    output t_item              o_item
);

    logic       w_is_digit;
    logic [7:0] w_digit_full;

    assign w_is_digit   = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign w_digit_full = i_char - CH_ZERO;

    always_comb begin
        o_item.star  = i_star;
        o_item.digit = w_digit_full[3:0];
        o_item.conv  = CONV_NONE;
        o_item.kind  = K_OTHER;
        if (w_is_digit) begin
            o_item.kind = K_DIGIT;
        end else begin
            unique case (i_char)
                CH_MINUS:   o_item.kind = K_MINUS;
                CH_STAR:    o_item.kind = K_STAR;
                CH_DOT:     o_item.kind = K_DOT;
                CH_LC_C:    begin o_item.kind = K_CONV; o_item.conv = CONV_C;       end
                CH_LC_S:    begin o_item.kind = K_CONV; o_item.conv = CONV_S;       end
                CH_LC_P:    begin o_item.kind = K_CONV; o_item.conv = CONV_P;       end
                CH_LC_D:    begin o_item.kind = K_CONV; o_item.conv = CONV_D;       end
                CH_LC_I:    begin o_item.kind = K_CONV; o_item.conv = CONV_I;       end
                CH_LC_U:    begin o_item.kind = K_CONV; o_item.conv = CONV_U;       end
                CH_LC_X:    begin o_item.kind = K_CONV; o_item.conv = CONV_LX;      end
                CH_UC_X:    begin o_item.kind = K_CONV; o_item.conv = CONV_UX;      end
                CH_PERCENT: begin o_item.kind = K_CONV; o_item.conv = CONV_PERCENT; end
                default:    o_item.kind = K_OTHER;
            endcase
        end
    end

endmodule

[rtl/fsp_queue.sv]
// Short request queue that decouples the classifier from the parser.
`timescale 1ns / 1ps

module fsp_queue
    import fsp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (w_pop)  r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            if (w_push && !w_pop)      r_count <= r_count + QCNT_W'(1);
            else if (w_pop && !w_push) r_count <= r_count - QCNT_W'(1);
        end
    end

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_full_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |=> o_full)
        else $error("full queue drained without a pop");

    a_pop_moves_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (r_rd_ptr == $past(r_rd_ptr) + QPTR_W'(1)))
        else $error("read pointer did not advance on pop");

endmodule

[rtl/fsp_back.sv]
// Back end: parse state machine, saturating accumulator and result register.
`timescale 1ns / 1ps

module fsp_back
    import fsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);

    typedef enum logic [2:0] {
        PH_INTRO,
        PH_FLAGS,
        PH_WDIG,
        PH_PCHK,
        PH_PSTRT,
        PH_PDIG,
        PH_CONV
    } t_phase;

    t_phase             r_phase,      n_phase;
    logic        [30:0] r_width,      n_width;
    logic signed [31:0] r_prec,       n_prec;
    logic               r_zero,       n_zero;
    logic               r_left,       n_left;
    logic               r_prec_given, n_prec_given;
    logic               r_out_valid;
    t_result            r_result;

    logic        w_emit;
    logic        w_slot_free;
    logic [30:0] w_acc_in;
    logic [34:0] w_acc_sum;
    logic [30:0] w_acc_out;
    logic [31:0] w_star_mag;
    logic [30:0] w_star_width;
    logic        w_is_digit;
    logic        w_res_prec_given;
    t_result     w_result;

    assign w_is_digit = (i_item.kind == K_DIGIT);

    // One multiply-by-ten-and-add, shared by width and precision digits
    assign w_acc_in  = ((r_phase == PH_PSTRT) || (r_phase == PH_PDIG)) ? r_prec[30:0] : r_width;
    assign w_acc_sum = {1'b0, w_acc_in, 3'b000} + {3'b000, w_acc_in, 1'b0}
                     + {31'd0, i_item.digit};
    assign w_acc_out = (w_acc_sum[34:31] != 4'd0) ? SAT_MAX : w_acc_sum[30:0];

    // Magnitude of a star width; the most negative argument saturates
    assign w_star_mag   = i_item.star[31] ? (32'd0 - i_item.star) : i_item.star;
    assign w_star_width = w_star_mag[31] ? SAT_MAX : w_star_mag[30:0];

    always_comb begin
        n_phase      = r_phase;
        n_width      = r_width;
        n_prec       = r_prec;
        n_zero       = r_zero;
        n_left       = r_left;
        n_prec_given = r_prec_given;
        w_emit       = 1'b0;
        unique case (r_phase)
            PH_FLAGS: begin
                if (w_is_digit && (i_item.digit == 4'd0)) begin
                    n_zero = 1'b1;
                end else if (i_item.kind == K_MINUS) begin
                    n_left = 1'b1;
                end else if (i_item.kind == K_STAR) begin
                    if (i_item.star[31]) n_left = 1'b1;
                    n_width = w_star_width;
                    n_phase = PH_PCHK;
                end else if (w_is_digit) begin
                    n_width = w_acc_out;
                    n_phase = PH_WDIG;
                end else if (i_item.kind == K_DOT) begin
                    n_prec_given = 1'b1;
                    n_prec       = '0;
                    n_phase      = PH_PSTRT;
                end else begin
                    w_emit = 1'b1;
                end
            end
            PH_WDIG: begin
                if (w_is_digit) begin
                    n_width = w_acc_out;
                end else if (i_item.kind == K_DOT) begin
                    n_prec_given = 1'b1;
                    n_prec       = '0;
                    n_phase      = PH_PSTRT;
                end else begin
                    w_emit = 1'b1;
                end
            end
            PH_PCHK: begin
                if (i_item.kind == K_DOT) begin
                    n_prec_given = 1'b1;
                    n_prec       = '0;
                    n_phase      = PH_PSTRT;
                end else begin
                    w_emit = 1'b1;
                end
            end
            PH_PSTRT: begin
                if (i_item.kind == K_STAR) begin
                    n_prec = i_item.star;
                    if (i_item.star[31]) n_prec_given = 1'b0;
                    n_phase = PH_CONV;
                end else if (w_is_digit) begin
                    n_prec  = {1'b0, w_acc_out};
                    n_phase = PH_PDIG;
                end else begin
                    w_emit = 1'b1;
                end
            end
            PH_PDIG: begin
                if (w_is_digit) begin
                    n_prec = {1'b0, w_acc_out};
                end else begin
                    w_emit = 1'b1;
                end
            end
            PH_CONV: begin
                w_emit = 1'b1;
            end
            default: begin
                // introducer: skip it and start a fresh specification
                n_phase      = PH_FLAGS;
                n_width      = '0;
                n_prec       = '0;
                n_zero       = 1'b0;
                n_left       = 1'b0;
                n_prec_given = 1'b0;
            end
        endcase
        if (w_emit) begin
            n_phase      = PH_INTRO;
            n_width      = '0;
            n_prec       = '0;
            n_zero       = 1'b0;
            n_left       = 1'b0;
            n_prec_given = 1'b0;
        end
    end

    // Result with the clearing rules applied
    always_comb begin
        w_res_prec_given = r_prec_given && (i_item.conv != CONV_C)
                        && (i_item.conv != CONV_PERCENT);
        w_result.conversion      = i_item.conv;
        w_result.left_justify    = r_left;
        w_result.field_width     = r_width;
        w_result.precision_given = w_res_prec_given;
        w_result.precision       = r_prec;
        w_result.char_consumed   = (i_item.conv != CONV_NONE);
        w_result.zero_pad        = r_zero && !r_left
                                && !(w_res_prec_given && (i_item.conv != CONV_S));
    end

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_pop       = i_valid && (!w_emit || w_slot_free);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_INTRO;
            r_width      <= '0;
            r_prec       <= '0;
            r_zero       <= 1'b0;
            r_left       <= 1'b0;
            r_prec_given <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase      <= n_phase;
                r_width      <= n_width;
                r_prec       <= n_prec;
                r_zero       <= n_zero;
                r_left       <= n_left;
                r_prec_given <= n_prec_given;
            end
            if (o_pop && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_result <= w_result;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(o_pop && w_emit))
        else $error("result overwritten while held");

    a_emit_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && w_emit) |=> (r_phase == PH_INTRO) && (r_width == '0))
        else $error("parser did not restart after a result");

    a_consumed_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.char_consumed == (r_result.conversion != CONV_NONE)))
        else $error("consumed flag disagrees with conversion");

    a_pad_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.zero_pad && r_result.left_justify))
        else $error("zero pad and left justify both set");

endmodule
